>>> rtl/core/hdaqi_pkg.sv
// ----------------------------------------------------------------------------
// hdaqi_pkg
// Shared constants, types and band tables for the hourly dust average block.
// ----------------------------------------------------------------------------
package hdaqi_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int COUNT_BITS  = 12;
    localparam int MAX_RESULTS = 8;
    localparam int REP_LIM     = (NUM_SENSORS < MAX_RESULTS) ? NUM_SENSORS : MAX_RESULTS;

    localparam int SIDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int RIDX_W  = $clog2(MAX_RESULTS + 1);
    localparam int CNT_W   = COUNT_BITS;
    localparam int SUM_W   = COUNT_BITS + 16;
    localparam int EDGE_W  = 13;
    localparam int PROD_W  = CNT_W + EDGE_W;
    localparam int DVD_W   = SUM_W + 8;
    localparam int DVS_W   = CNT_W + 12;
    localparam int STEP_W  = $clog2(DVD_W + 1);

    localparam logic [CNT_W-1:0] COUNT_FULL = '1;

    localparam logic [1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SENSORS    = 2'd2;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_CLOSE     = 1'b1;
    localparam logic KIND_CHECK   = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [8:0] AQI_MAX  = 9'd500;
    localparam logic [2:0] BAND_MAX = 3'd6;

    typedef struct packed {
        logic              op;
        logic [3:0]        sn;
        logic [15:0]       v;
        logic              outl;
        logic              bad_sn;
        logic [RIDX_W-1:0] nrep;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  sensor_id;
        logic        is_outlier;
        logic        dropped;
        logic        has_data;
        logic [11:0] sample_count;
        logic [15:0] average_tenths;
        logic [8:0]  aqi_index;
        logic [2:0]  band;
        logic        last;
    } result_t;

    // band edges in tenths of ug/m3
    function automatic logic [EDGE_W-1:0] edge_in(input logic [2:0] b);
        logic [EDGE_W-1:0] e;
        case (b)
            3'd0:    e = 13'd0;
            3'd1:    e = 13'd120;
            3'd2:    e = 13'd355;
            3'd3:    e = 13'd555;
            3'd4:    e = 13'd1505;
            3'd5:    e = 13'd2505;
            3'd6:    e = 13'd3505;
            default: e = 13'd5505;
        endcase
        return e;
    endfunction

    function automatic logic [8:0] edge_out(input logic [2:0] b);
        logic [8:0] e;
        case (b)
            3'd0:    e = 9'd0;
            3'd1:    e = 9'd50;
            3'd2:    e = 9'd100;
            3'd3:    e = 9'd150;
            3'd4:    e = 9'd200;
            3'd5:    e = 9'd300;
            3'd6:    e = 9'd400;
            default: e = 9'd500;
        endcase
        return e;
    endfunction

    function automatic logic [EDGE_W-1:0] band_in_span(input logic [2:0] b);
        return edge_in(b + 3'd1) - edge_in(b);
    endfunction

    function automatic logic [8:0] band_out_span(input logic [2:0] b);
        return edge_out(b + 3'd1) - edge_out(b);
    endfunction

endpackage

>>> rtl/core/hdaqi_front.sv
// ----------------------------------------------------------------------------
// hdaqi_front
// Configuration registers, sample classification and a two-entry item queue.
// ----------------------------------------------------------------------------
module hdaqi_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [3:0]           s_sensor_number,
    input  logic [15:0]          s_value_tenths,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 q_valid,
    output hdaqi_pkg::item_t     q_item,
    input  logic                 q_pop
);
    import hdaqi_pkg::*;

    logic [15:0] low_reg;
    logic [15:0] high_reg;
    logic [3:0]  siu_reg;
    item_t       fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    item_t       entry;
    logic        push;

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        entry.op     = s_opcode;
        entry.sn     = s_sensor_number;
        entry.v      = s_value_tenths;
        entry.outl   = (s_value_tenths < low_reg) || (s_value_tenths > high_reg);
        entry.bad_sn = (s_sensor_number == 4'd0) || (32'(s_sensor_number) > NUM_SENSORS);
        if (siu_reg == 4'd0) begin
            entry.nrep = RIDX_W'(1);
        end else if (32'(siu_reg) > REP_LIM) begin
            entry.nrep = RIDX_W'(REP_LIM);
        end else begin
            entry.nrep = RIDX_W'(siu_reg);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (push && !q_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && q_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= 16'd50;
            high_reg   <= 16'd5505;
            siu_reg    <= 4'd8;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_LOW_LIMIT:  low_reg  <= cfg_data;
                    CFG_HIGH_LIMIT: high_reg <= cfg_data;
                    CFG_SENSORS:    siu_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/core/hdaqi_div.sv
// ----------------------------------------------------------------------------
// hdaqi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hdaqi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hdaqi_pkg::DVD_W-1:0] dividend,
    input  logic [hdaqi_pkg::DVS_W-1:0] divisor,
    output logic                        done,
    output logic [hdaqi_pkg::DVD_W-1:0] quotient
);
    import hdaqi_pkg::*;

    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  d_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign ge       = (trial >= {1'b0, d_reg});
    assign diff     = trial - {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end else if (run_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end else if (run_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

endmodule

>>> rtl/core/hdaqi_back.sv
// ----------------------------------------------------------------------------
// hdaqi_back
// Hourly accumulators, report sequencer and result register.
// ----------------------------------------------------------------------------
module hdaqi_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  hdaqi_pkg::item_t     q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hdaqi_pkg::result_t   m_result
);
    import hdaqi_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_LOAD     = 12'b000000000010,
        ST_CHK      = 12'b000000000100,
        ST_BAND     = 12'b000000001000,
        ST_AVG_GO   = 12'b000000010000,
        ST_AVG_WAIT = 12'b000000100000,
        ST_P1       = 12'b000001000000,
        ST_P2       = 12'b000010000000,
        ST_P3       = 12'b000100000000,
        ST_AQI_GO   = 12'b001000000000,
        ST_AQI_WAIT = 12'b010000000000,
        ST_EMIT     = 12'b100000000000
    } state_t;

    state_t            st_reg;
    state_t            st_next;
    logic [SUM_W-1:0]  sum_reg [NUM_SENSORS];
    logic [CNT_W-1:0]  cnt_reg [NUM_SENSORS];
    logic [RIDX_W-1:0] idx_reg;
    logic [RIDX_W-1:0] n_reg;
    logic [SUM_W-1:0]  s_reg;
    logic [CNT_W-1:0]  c_reg;
    logic [2:0]        b_reg;
    logic              sat_reg;
    logic [15:0]       avg_reg;
    logic [8:0]        aqi_reg;
    logic [SUM_W-1:0]  diff_reg;
    logic [DVD_W-1:0]  num_reg;
    logic [DVS_W-1:0]  den_reg;
    result_t           out_reg;
    logic              m_valid_reg;

    logic              out_free;
    logic [SIDX_W-1:0] samp_idx;
    logic [SIDX_W-1:0] rep_idx;
    logic              full;
    logic              accum;
    logic [2:0]        edge_sel;
    logic [PROD_W-1:0] prod;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;
    logic              rep_last;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;
    assign samp_idx = SIDX_W'(32'(q_item.sn) - 1);
    assign rep_idx  = SIDX_W'(idx_reg);
    assign full     = (cnt_reg[samp_idx] == COUNT_FULL);
    assign accum    = !q_item.outl && !q_item.bad_sn && !full;
    assign q_pop    = (st_reg == ST_IDLE) && q_valid && ((q_item.op == OP_CLOSE) || out_free);
    assign rep_last = ((idx_reg + RIDX_W'(1)) == n_reg);

    // shared edge multiplier for the top-edge check and the band search
    assign edge_sel = (st_reg == ST_CHK) ? 3'd7 : (b_reg + 3'd1);
    assign prod     = PROD_W'(edge_in(edge_sel)) * PROD_W'(c_reg);

    assign div_start = (st_reg == ST_AVG_GO) || (st_reg == ST_AQI_GO);
    assign div_dvd   = (st_reg == ST_AVG_GO) ? (DVD_W'({s_reg, 1'b0}) + DVD_W'(c_reg))
                                             : ({num_reg[DVD_W-2:0], 1'b0} + DVD_W'(den_reg));
    assign div_dvs   = (st_reg == ST_AVG_GO) ? DVS_W'({c_reg, 1'b0})
                                             : {den_reg[DVS_W-2:0], 1'b0};

    hdaqi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (q_pop && (q_item.op == OP_CLOSE)) begin
                    st_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                st_next = (cnt_reg[rep_idx] == '0) ? ST_EMIT : ST_CHK;
            end
            ST_CHK: begin
                st_next = (SUM_W'(s_reg) > SUM_W'(prod)) ? ST_AVG_GO : ST_BAND;
            end
            ST_BAND: begin
                if (!((b_reg < BAND_MAX) && (SUM_W'(s_reg) >= SUM_W'(prod)))) begin
                    st_next = ST_AVG_GO;
                end
            end
            ST_AVG_GO:   st_next = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (div_done) begin
                    st_next = sat_reg ? ST_EMIT : ST_P1;
                end
            end
            ST_P1:       st_next = ST_P2;
            ST_P2:       st_next = ST_P3;
            ST_P3:       st_next = ST_AQI_GO;
            ST_AQI_GO:   st_next = ST_AQI_WAIT;
            ST_AQI_WAIT: begin
                if (div_done) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    st_next = rep_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            n_reg       <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            st_reg <= st_next;
            if ((q_pop && (q_item.op == OP_SAMPLE)) || ((st_reg == ST_EMIT) && out_free)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_item.op == OP_SAMPLE) begin
                    if (accum) begin
                        sum_reg[samp_idx] <= sum_reg[samp_idx] + SUM_W'(q_item.v);
                        cnt_reg[samp_idx] <= cnt_reg[samp_idx] + CNT_W'(1);
                    end
                end else begin
                    idx_reg <= '0;
                    n_reg   <= q_item.nrep;
                end
            end
            if ((st_reg == ST_EMIT) && out_free) begin
                idx_reg     <= idx_reg + RIDX_W'(1);
                if (rep_last) begin
                    // hour closed: start the next one empty
                    for (int i = 0; i < NUM_SENSORS; i++) begin
                        sum_reg[i] <= '0;
                        cnt_reg[i] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_LOAD: begin
                s_reg   <= sum_reg[rep_idx];
                c_reg   <= cnt_reg[rep_idx];
                b_reg   <= 3'd0;
                sat_reg <= 1'b0;
                avg_reg <= 16'd0;
                aqi_reg <= 9'd0;
            end
            ST_CHK: begin
                if (SUM_W'(s_reg) > SUM_W'(prod)) begin
                    sat_reg <= 1'b1;
                    aqi_reg <= AQI_MAX;
                    b_reg   <= BAND_MAX;
                end
            end
            ST_BAND: begin
                if ((b_reg < BAND_MAX) && (SUM_W'(s_reg) >= SUM_W'(prod))) begin
                    b_reg <= b_reg + 3'd1;
                end
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    avg_reg <= div_quo[15:0];
                end
            end
            ST_P1: diff_reg <= s_reg - SUM_W'(PROD_W'(edge_in(b_reg)) * PROD_W'(c_reg));
            ST_P2: num_reg  <= DVD_W'(DVD_W'(diff_reg) * DVD_W'(band_out_span(b_reg)));
            ST_P3: den_reg  <= DVS_W'(DVS_W'(band_in_span(b_reg)) * DVS_W'(c_reg));
            ST_AQI_WAIT: begin
                if (div_done) begin
                    aqi_reg <= edge_out(b_reg) + div_quo[8:0];
                end
            end
            default: ;
        endcase

        if (q_pop && (q_item.op == OP_SAMPLE)) begin
            out_reg.kind           <= KIND_CHECK;
            out_reg.sensor_id      <= q_item.sn;
            out_reg.is_outlier     <= q_item.outl;
            out_reg.dropped        <= q_item.bad_sn || (!q_item.outl && full);
            out_reg.has_data       <= 1'b0;
            out_reg.sample_count   <= 12'd0;
            out_reg.average_tenths <= 16'd0;
            out_reg.aqi_index      <= 9'd0;
            out_reg.band           <= 3'd0;
            out_reg.last           <= 1'b1;
        end else if ((st_reg == ST_EMIT) && out_free) begin
            out_reg.kind           <= KIND_REPORT;
            out_reg.sensor_id      <= 4'(idx_reg + RIDX_W'(1));
            out_reg.is_outlier     <= 1'b0;
            out_reg.dropped        <= 1'b0;
            out_reg.has_data       <= (c_reg != '0);
            out_reg.sample_count   <= 12'(c_reg);
            out_reg.average_tenths <= avg_reg;
            out_reg.aqi_index      <= aqi_reg;
            out_reg.band           <= (c_reg != '0) ? b_reg : 3'd0;
            out_reg.last           <= rep_last;
        end
    end

endmodule

>>> rtl/core/hourly_dust_average_aqi_top.sv
// ----------------------------------------------------------------------------
// hourly_dust_average_aqi_top
// Hourly dust averaging with outlier check and PM2.5 air quality index.
// ----------------------------------------------------------------------------
// A sample item gives one check result. An hour-close item gives one report
// per sensor in use. A sensor with no samples goes from the load state straight
// to emit. Any other report runs the top-edge check and a band search on the
// one edge multiplier, then the average and the AQI scaling on the bit-serial
// divider that is shared by both; a mean above the top band edge skips the AQI
// division. Output stalls hold a report in the emit state. A two-entry queue
// lets new items be taken while a report is being worked out.
module hourly_dust_average_aqi_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [3:0]  s_sensor_number,
    input  logic [15:0] s_value_tenths,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [3:0]  m_sensor_id,
    output logic        m_is_outlier,
    output logic        m_dropped,
    output logic        m_has_data,
    output logic [11:0] m_sample_count,
    output logic [15:0] m_average_tenths,
    output logic [8:0]  m_aqi_index,
    output logic [2:0]  m_band,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hdaqi_pkg::*;

    item_t   q_item;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    hdaqi_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_sensor_number (s_sensor_number),
        .s_value_tenths  (s_value_tenths),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    hdaqi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (res)
    );

    assign m_kind           = res.kind;
    assign m_sensor_id      = res.sensor_id;
    assign m_is_outlier     = res.is_outlier;
    assign m_dropped        = res.dropped;
    assign m_has_data       = res.has_data;
    assign m_sample_count   = res.sample_count;
    assign m_average_tenths = res.average_tenths;
    assign m_aqi_index      = res.aqi_index;
    assign m_band           = res.band;
    assign m_last           = res.last;

`ifndef SYNTHESIS
    a_check_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_CHECK)) |-> m_last)
        else $error("check result without last");

    a_check_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_CHECK)) |-> (!m_has_data && (m_sample_count == 12'd0)))
        else $error("check result carries report data");

    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_REPORT) && !m_has_data)
            |-> ((m_sample_count == 12'd0) && (m_aqi_index == 9'd0)))
        else $error("empty report carries data");

    a_aqi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_aqi_index <= AQI_MAX) && (m_band <= BAND_MAX)))
        else $error("aqi or band out of range");
`endif

endmodule
